[hw/rtl/fpm_pkg.sv]
// shared constants and stage payload type for the float32 multiplier
package fpm_pkg;
    localparam int unsigned ExpBias = 127;
    localparam int unsigned ExpMaxNormal = 254;
    localparam int unsigned SigBits = 24;
    localparam int unsigned FracBits = 23;
    localparam int unsigned NumCells = 4;
    localparam logic [31:0] WordPosInf = 32'h7F80_0000;

    typedef struct packed {
        logic        special;
        logic [31:0] special_word;
        logic        sign;
        logic [9:0]  exp_s;
        logic [47:0] prod;
        logic [23:0] sig;
        logic [31:0] word;
    } t_lane;
endpackage

[hw/rtl/float32_multiplier.sv]
// float32 multiplier top level: chain of four pipeline cells
// an accepted input beat is registered in each of the four cells in turn before output valid
// throughput: one beat per cycle while the output is not stalled, set by the four-cell chain with one multiply cell
// stall ripples back through the cells combinationally
// reset clears all cell valid bits; payload is not reset
module float32_multiplier
    import fpm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_operand_a,
    input  logic [31:0] i_operand_b,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_product
);
    logic  w_v [NumCells+1];
    logic  w_s [NumCells+1];
    t_lane w_l [NumCells+1];

    always_comb begin
        w_l[0] = '0;
        w_l[0].word = i_operand_a;
        w_l[0].special_word = i_operand_b;
    end
    assign w_v[0] = i_valid;
    assign o_stall = w_s[0];
    assign w_s[NumCells] = i_stall;

    for (genvar g = 0; g < NumCells; g++) begin : g_cell
        fpm_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_stage(2'(g)),
            .i_valid(w_v[g]),
            .o_stall(w_s[g]),
            .i_lane (w_l[g]),
            .o_valid(w_v[g+1]),
            .i_stall(w_s[g+1]),
            .o_lane (w_l[g+1])
        );
    end

    assign o_valid   = w_v[NumCells];
    assign o_product = w_l[NumCells].word;
endmodule

[hw/rtl/fpm_cell.sv]
// one pipeline cell: register slot with valid and stall forwarding, op chosen by stage index
module fpm_cell
    import fpm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_stage,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_lane      i_lane,
    output logic       o_valid,
    input  logic       i_stall,
    output t_lane      o_lane
);
    logic  r_valid;
    t_lane r_lane;
    t_lane n_lane;
    logic  w_load;
    logic [23:0] w_sa, w_sb, w_sig;
    logic [31:0] w_ma, w_mb;
    logic [47:0] w_p;
    logic [9:0]  w_e, w_t;
    logic [24:0] w_r;
    logic        w_rnd, w_stk;

    assign o_stall = r_valid && i_stall;
    assign w_load  = !o_stall;

    always_comb begin
        n_lane = i_lane;
        w_ma = i_lane.word & 32'h7FFF_FFFF;
        w_mb = i_lane.special_word & 32'h7FFF_FFFF;
        w_sa = {(w_ma[30:23] != 8'd0), w_ma[22:0]};
        w_sb = {(w_mb[30:23] != 8'd0), w_mb[22:0]};
        w_p = i_lane.prod;
        w_e = i_lane.exp_s;
        w_sig = w_p[47:24];
        w_rnd = w_p[23];
        w_stk = (w_p[22:0] != 23'd0);
        w_r = {1'b0, w_sig} + 25'd1;
        w_t = 10'd1 - w_e;
        unique case (i_stage)
            2'd0: begin
                // operand a in word, operand b in special_word
                n_lane.sign = i_lane.word[31] ^ i_lane.special_word[31];
                n_lane.special = (w_ma == 32'd0) || (w_mb == 32'd0);
                n_lane.special_word = (((w_ma == 32'd0) && (w_mb == WordPosInf)) ||
                    ((w_mb == 32'd0) && (w_ma == WordPosInf))) ? WordPosInf : 32'd0;
                n_lane.exp_s = 10'({2'b0, w_ma[30:23]}) + 10'({2'b0, w_mb[30:23]})
                    - 10'(ExpBias);
                n_lane.prod = w_sa * w_sb;
            end
            2'd1: begin
                if (w_p[47]) begin
                    n_lane.exp_s = w_e + 10'd1;
                end else begin
                    n_lane.prod = {w_p[46:0], 1'b0};
                end
            end
            2'd2: begin
                n_lane.sig = w_sig;
                if (w_rnd && (w_stk || w_sig[0])) begin
                    if (w_r[24]) begin
                        n_lane.sig = w_r[24:1];
                        n_lane.exp_s = w_e + 10'd1;
                    end else begin
                        n_lane.sig = w_r[23:0];
                    end
                end
            end
            default: begin
                n_lane.word = 32'd0;
                if (i_lane.special) begin
                    n_lane.word = i_lane.special_word;
                end else if (!w_e[9] && (w_e > 10'(ExpMaxNormal))) begin
                    n_lane.word = WordPosInf;
                end else if (w_e[9] || (w_e == 10'd0)) begin
                    if (w_t < 10'(SigBits)) begin
                        n_lane.sig = i_lane.sig >> w_t[4:0];
                        n_lane.word = {i_lane.sign, 8'(n_lane.sig[23] ? 8'd1 : 8'd0),
                            n_lane.sig[22:0]};
                    end
                end else begin
                    n_lane.word = {i_lane.sign, i_lane.sig[23] ? w_e[7:0] : 8'd0,
                        i_lane.sig[22:0]};
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_valid;
        end
        if (w_load && i_valid) begin
            r_lane <= n_lane;
        end
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;
endmodule

[hw/rtl/fpm_checker.sv]
// port-level checker for the float32 multiplier, bound to the top level
module fpm_checker
    import fpm_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_product
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_product))
        else $error("stalled output beat changed");
    a_no_stall_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled without output stall");
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_stall ##1 !i_stall ##1 !i_stall ##1 !i_stall |=> o_valid)
        else $error("beat not delivered after four cycles");
endmodule

bind float32_multiplier fpm_checker u_fpm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_valid),
    .o_stall  (o_stall),
    .o_valid  (o_valid),
    .i_stall  (i_stall),
    .o_product(o_product)
);

[sim/float32_multiplier_test.sv]
// self-checking testbench for the float32 multiplier: directed table, then random beats
module float32_multiplier_test
    import fpm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RandBeats = 1100;
    localparam int CycleLimit = 200000;
    localparam int NumRows = 20;

    typedef struct {
        logic [31:0] a;
        logic [31:0] b;
        logic        known;
        logic [31:0] prod;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [31:0] i_operand_a = '0;
    logic [31:0] i_operand_b = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_product;

    logic [31:0] product_queue[$];
    int          errors = 0;
    int          beats_out = 0;
    int          cycles = 0;
    bit          feed_done = 1'b0;
    bit          no_idle = 1'b0;
    bit          hold_off = 1'b0;
    t_row        rows[NumRows];

    float32_multiplier i_dut (.*);

    always #5 i_clk = ~i_clk;

    // binary32 product: hidden bit, one-bit normalize, round to nearest even
    function automatic logic [31:0] fp_product(logic [31:0] a, logic [31:0] b);
        logic [30:0] ma, mb;
        logic [23:0] sa, sb;
        logic [47:0] p;
        logic [24:0] sig;
        logic        rnd, sticky;
        int          e, t;
        ma = a[30:0];
        mb = b[30:0];
        if (ma == '0 || mb == '0) begin
            if ((ma == '0 && mb == WordPosInf[30:0]) || (mb == '0 && ma == WordPosInf[30:0]))
                return WordPosInf;
            return '0;
        end
        e = int'(a[30:23]) + int'(b[30:23]) - int'(ExpBias);
        sa = {a[30:23] != 0, a[22:0]};
        sb = {b[30:23] != 0, b[22:0]};
        p = sa * sb;
        if (p[47]) e++;
        else p = p << 1;
        sig = {1'b0, p[47:24]};
        rnd = p[23];
        sticky = |p[22:0];
        if (rnd && (sticky || sig[0])) begin
            sig = sig + 1;
            if (sig[24]) begin
                sig = sig >> 1;
                e++;
            end
        end
        if (e > int'(ExpMaxNormal)) return WordPosInf;
        if (e < 1) begin
            t = 1 - e;
            if (t >= int'(SigBits)) return '0;
            sig = sig >> t;
            e = 1;
        end
        return {a[31] ^ b[31], sig[23] ? 8'(e) : 8'd0, sig[22:0]};
    endfunction

    // random operand, biased toward exponents near the bias, exponent extremes and zeros
    function automatic logic [31:0] rand_operand();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 9))
            0: w[30:23] = 8'(ExpBias) + 8'($urandom_range(0, 3)) - 8'd1;
            1: w[30:23] = 8'd0;
            2: w[30:23] = 8'($urandom_range(250, 255));
            3: w[30:0] = '0;
            4: w[30:23] = 8'($urandom_range(0, 20));
            default: ;
        endcase
        return w;
    endfunction

    task automatic send(logic [31:0] a, logic [31:0] b);
        while (!no_idle && $urandom_range(0, 99) < 19) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_operand_a <= a;
        i_operand_b <= b;
        product_queue = {product_queue, fp_product(a, b)};
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        rows = '{
            '{32'h3F80_0000, 32'h3F80_0000, 1'b1, 32'h3F80_0000},
            '{32'h0000_0000, 32'h7F80_0000, 1'b1, WordPosInf},
            '{32'hFF80_0000, 32'h8000_0000, 1'b1, WordPosInf},
            '{32'h8000_0000, 32'h4040_0000, 1'b1, 32'h0000_0000},
            '{32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
            '{32'h7F7F_FFFF, 32'h7F7F_FFFF, 1'b1, WordPosInf},
            '{32'hFF7F_FFFF, 32'h4000_0000, 1'b1, WordPosInf},
            '{32'h0080_0000, 32'h0080_0000, 1'b1, 32'h0000_0000},
            '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
            '{32'h7FC0_0000, 32'h3F80_0000, 1'b0, '0},
            '{32'h0000_0001, 32'h3F80_0000, 1'b0, '0},
            '{32'h007F_FFFF, 32'h4000_0000, 1'b0, '0},
            '{32'h0080_0000, 32'h3F00_0000, 1'b0, '0},
            '{32'h0080_0000, 32'h3E80_0000, 1'b0, '0},
            '{32'h3F80_0001, 32'h3F7F_FFFF, 1'b0, '0},
            '{32'h3FFF_FFFF, 32'h3FFF_FFFF, 1'b0, '0},
            '{32'h3F80_0001, 32'h3F80_0001, 1'b0, '0},
            '{32'h4B80_0001, 32'h3F40_0000, 1'b0, '0},
            '{32'hBFC0_0000, 32'h4040_0000, 1'b0, '0},
            '{32'h0040_0000, 32'h7F00_0000, 1'b0, '0}
        };
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (rows[r]) begin
            send(rows[r].a, rows[r].b);
            // typed-in result must also agree with the predictor
            if (rows[r].known && product_queue[$] !== rows[r].prod) begin
                $error("row %0d product: expected %h, predicted %h", r, rows[r].prod,
                       product_queue[$]);
                errors++;
            end
        end
        for (int n = 0; n < RandBeats; n++) begin
            no_idle = (n >= 300 && n < 500);
            hold_off = (n >= 600 && n < 640);
            send(rand_operand(), rand_operand());
        end
        i_valid <= 1'b0;
        feed_done = 1'b1;
    end

    // receiver stall: random, a quiet stretch, and repeated long hold-offs in one window
    initial begin
        int held;
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                held = 0;
                while (held < 60) begin
                    i_stall <= 1'b1;
                    held++;
                    @(negedge i_clk);
                end
            end
            i_stall <= !no_idle && ($urandom_range(0, 99) < 19);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (product_queue.size() == 0) begin
                $error("product beat %h with nothing expected", o_product);
                errors++;
            end else begin
                logic [31:0] want;
                want = product_queue.pop_front();
                if (o_product !== want) begin
                    $error("product: expected %h, actual %h", want, o_product);
                    errors++;
                end
            end
            beats_out++;
        end
    end

    initial begin
        wait (feed_done && product_queue.size() == 0);
        repeat (10) @(posedge i_clk);
        $display("covered %0d table rows and %0d random operand pairs, %0d products checked",
                 NumRows, RandBeats, beats_out);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end
endmodule

[filelist.f]
hw/rtl/fpm_pkg.sv
hw/rtl/fpm_cell.sv
hw/rtl/float32_multiplier.sv
hw/rtl/fpm_checker.sv
sim/float32_multiplier_test.sv
